// ===== hw/rtl/rsb_pkg.sv =====
// ----------------------------------------------------------------------------
// rsb_pkg
// Shared field widths, sequencer state codes and the result record of the
// RMS-of-sample-block core.
// ----------------------------------------------------------------------------
package rsb_pkg;

  // Stream field widths
  localparam int unsigned SAMPLE_FIELD_W = 16;
  localparam int unsigned RMS_FIELD_W    = 16;
  localparam int unsigned COUNT_FIELD_W  = 11;
  localparam int unsigned IN_TDATA_W     = 16;
  localparam int unsigned OUT_TDATA_W    = 32;
  localparam int unsigned OUT_PAD_W      = OUT_TDATA_W - RMS_FIELD_W - COUNT_FIELD_W;

  // Sequencer state codes
  typedef logic [2:0] state_t;
  localparam state_t ST_IDLE = 3'd0;
  localparam state_t ST_SQR  = 3'd1;
  localparam state_t ST_ACC  = 3'd2;
  localparam state_t ST_DIV  = 3'd3;
  localparam state_t ST_ROOT = 3'd4;
  localparam state_t ST_OUT  = 3'd5;

  typedef struct packed {
    logic                     overflow;
    logic [COUNT_FIELD_W-1:0] sample_count;
    logic [RMS_FIELD_W-1:0]   rms;
  } result_t;

endpackage

// ===== hw/rtl/rms_of_sample_block_core.sv =====
// ----------------------------------------------------------------------------
// rms_of_sample_block_core
// Integer root mean square over a block of signed samples, with the divide
// and the square root done bit by bit on one shared subtract-compare unit.
// ----------------------------------------------------------------------------
//
// Channel  | Dir | Accept on                     | Payload
// ---------+-----+-------------------------------+------------------------------
// s_axis   | in  | s_axis_tvalid & s_axis_tready | tdata = sample, tlast = last
// m_axis   | out | m_axis_tvalid & m_axis_tready | tdata = rms, count; tuser = ovf
//
// Steps: a sample is accepted, squared and accumulated, or only accepted when
// dropped from a full block. A tlast sample adds ACC_W divide and RT_W root
// steps and a hand-over step, with divide and root done one bit per cycle on
// the shared unit. Reset (rst_ni low, asynchronous) clears the sum, count,
// overflow flag and the output slot. A stalled result waits in the output
// register; the next block's samples are still taken, and only the hand-over
// step waits for it.
// ----------------------------------------------------------------------------
module rms_of_sample_block_core
  import rsb_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // slave side
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] sample
  input  logic                   s_axis_tlast,   // last_sample
  // master side
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [15:0] rms, [26:16] sample_count
  output logic                   m_axis_tuser    // [0] overflow
);

  // Derived widths
  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned SQ_W   = 2 * SB - 1;                       // one square
  localparam int unsigned SUM_W  = SQ_W + $clog2(MAX_SAMPLES);       // full sum
  localparam int unsigned RT_W   = (SUM_W + 1) / 2;                  // root digits
  localparam int unsigned ACC_W  = 2 * RT_W;                         // even-sized sum
  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned UNIT_W = (CNT_W + 1 > RT_W + 3) ? CNT_W + 1 : RT_W + 3;
  localparam int unsigned STEP_W = $clog2(ACC_W + 1);

  // Registers
  state_t            state_q, state_d;
  logic [ACC_W-1:0]  acc_q, acc_d;      // sum of squares, then quotient, then radicand
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              drop_q, drop_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_vld_q, out_vld_d;
  logic [SB-1:0]     mag_q, mag_d;
  logic [SQ_W-1:0]   prod_q, prod_d;
  logic              last_q, last_d;
  logic [UNIT_W-1:0] rem_q, rem_d;
  logic [RT_W-1:0]   root_q, root_d;
  result_t           res_q, res_d;

  // Input sample, sized to SAMPLE_BITS
  logic [IN_TDATA_W+SB-1:0] sample_ext;
  logic [SB-1:0]            raw;
  logic [SB-1:0]            mag_in;
  logic [2*SB-1:0]          sq_full;
  logic                     s_xfer;
  logic                     full;

  assign sample_ext = {{SB{1'b0}}, s_axis_tdata};
  assign raw        = sample_ext[SB-1:0];
  // Two's complement magnitude; the most negative value gives 2^(SB-1) unsigned.
  assign mag_in     = raw[SB-1] ? (~raw + SB'(1)) : raw;
  assign sq_full    = {{SB{1'b0}}, mag_q} * {{SB{1'b0}}, mag_q};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign full          = (cnt_q == CNT_W'(MAX_SAMPLES));

  // Shared subtract-compare unit: restoring divide step or root digit step
  logic [UNIT_W-1:0] op_a, op_b;
  logic [UNIT_W:0]   diff;
  logic              ge;

  always_comb begin
    if (state_q == ST_ROOT) begin
      op_a = {rem_q[UNIT_W-3:0], acc_q[ACC_W-1 -: 2]};
      op_b = {{(UNIT_W-RT_W-2){1'b0}}, root_q, 2'b01};
    end else begin
      op_a = {rem_q[UNIT_W-2:0], acc_q[ACC_W-1]};
      op_b = {{(UNIT_W-CNT_W){1'b0}}, cnt_q};
    end
  end

  assign diff = {1'b0, op_a} - {1'b0, op_b};
  assign ge   = ~diff[UNIT_W];

  // Root and count resized to the result fields
  logic [RT_W+RMS_FIELD_W-1:0]   root_ext;
  logic [CNT_W+COUNT_FIELD_W-1:0] cnt_ext;
  assign root_ext = {{RMS_FIELD_W{1'b0}}, root_q};
  assign cnt_ext  = {{COUNT_FIELD_W{1'b0}}, cnt_q};

  // Sequencer
  always_comb begin
    state_d   = state_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    drop_d    = drop_q;
    step_d    = step_q;
    out_vld_d = out_vld_q;
    mag_d     = mag_q;
    prod_d    = prod_q;
    last_d    = last_q;
    rem_d     = rem_q;
    root_d    = root_q;
    res_d     = res_q;

    // Free the output slot on a completed transfer
    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_xfer) begin
          mag_d  = mag_in;
          last_d = s_axis_tlast;
          if (full) begin
            // Block already full: drop the sample, flag it
            drop_d = 1'b1;
            if (s_axis_tlast) begin
              state_d = ST_DIV;
              rem_d   = '0;
              step_d  = '0;
            end
          end else begin
            state_d = ST_SQR;
          end
        end
      end
      ST_SQR: begin
        prod_d  = sq_full[SQ_W-1:0];
        state_d = ST_ACC;
      end
      ST_ACC: begin
        acc_d = acc_q + {{(ACC_W-SQ_W){1'b0}}, prod_q};
        cnt_d = cnt_q + CNT_W'(1);
        if (last_q) begin
          state_d = ST_DIV;
          rem_d   = '0;
          step_d  = '0;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        // Shift the quotient bit in where the dividend bit leaves
        acc_d  = {acc_q[ACC_W-2:0], ge};
        rem_d  = ge ? diff[UNIT_W-1:0] : op_a;
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(ACC_W - 1)) begin
          state_d = ST_ROOT;
          rem_d   = '0;
          root_d  = '0;
          step_d  = '0;
        end
      end
      ST_ROOT: begin
        acc_d  = {acc_q[ACC_W-3:0], 2'b00};
        rem_d  = ge ? diff[UNIT_W-1:0] : op_a;
        root_d = {root_q[RT_W-2:0], ge};
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(RT_W - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // Hold until the output slot is free, then load and clear the block
        if (!out_vld_q || m_axis_tready) begin
          res_d.rms          = root_ext[RMS_FIELD_W-1:0];
          res_d.sample_count = cnt_ext[COUNT_FIELD_W-1:0];
          res_d.overflow     = drop_q;
          out_vld_d          = 1'b1;
          acc_d              = '0;
          cnt_d              = '0;
          drop_d             = 1'b0;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      acc_q     <= '0;
      cnt_q     <= '0;
      drop_q    <= 1'b0;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      acc_q     <= acc_d;
      cnt_q     <= cnt_d;
      drop_q    <= drop_d;
      step_q    <= step_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    prod_q <= prod_d;
    last_q <= last_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    res_q  <= res_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, res_q.sample_count, res_q.rms};
  assign m_axis_tuser  = res_q.overflow;

`ifndef SYNTH
  // Count never passes the block limit
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_SAMPLES))
    else $error("sample count above limit");

  // A sample taken into a block that is not full is counted after its square and accumulate states
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_xfer && !full) |-> ##3 (cnt_q == $past(cnt_q, 3) + CNT_W'(1)))
    else $error("accepted sample not counted");

  // Overflow is only flagged on a full block
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q |-> full)
    else $error("overflow flag set on a block that is not full");

  // Partial remainder of the divide stays below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < {{(UNIT_W-CNT_W){1'b0}}, cnt_q}))
    else $error("divide remainder not below count");
`endif

endmodule
